// ----- rtl/csm_pkg.sv -----
// Shared types, constants and the saturating adder of the sparse matrix-vector block.
`default_nettype none
package csm_pkg;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 64;
    localparam int IDX_W    = 10;
    localparam int NROW_W   = 11;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_CW    = 3;

    localparam logic [NROW_W-1:0] ROW_LIMIT = 11'd1024;
    localparam logic [2:0] REG_TRANSPOSE = 3'd0;
    localparam logic [2:0] REG_NUM_ROWS  = 3'd4;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_LOAD,
        ACT_NONZERO,
        ACT_EMPTY,
        ACT_READ
    } t_action;

    typedef enum logic [2:0] {
        K_LOAD,
        K_MAC,
        K_EMPTY,
        K_ADVANCE,
        K_SCATTER,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         idx;
        logic signed [VAL_W-1:0]  val;
        logic                     last;
    } t_op;

    typedef struct packed {
        logic signed [SUM_W-1:0]  value;
        logic [IDX_W-1:0]         row;
        logic                     ovf;
    } t_result;

    // returns {saturated, sum}
    function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] a,
                                               input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W-1:0] s;
        s = a + b;
        if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
            return {1'b1, (a[SUM_W-1] ? SUM_MIN : SUM_MAX)};
        end
        return {1'b0, s};
    endfunction
endpackage
`default_nettype wire

// ----- rtl/csm_front.sv -----
// Front end: accepts items, classifies them by mode and holds them in a short queue.
`default_nettype none
module csm_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  wire [1:0]                   i_action,
    input  wire [csm_pkg::IDX_W-1:0]    i_index,
    input  wire signed [csm_pkg::VAL_W-1:0] i_value,
    input  wire                         i_row_end,
    input  wire                         i_transpose,
    input  wire                         i_hold,
    output logic                        o_full,
    input  wire                         i_pop,
    output logic                        o_valid,
    output csm_pkg::t_op                o_op
);
    import csm_pkg::*;

    t_op        r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_op        w_op;
    logic       w_acc, w_deq;

    always_comb begin
        w_op.idx  = i_index;
        w_op.val  = i_value;
        w_op.last = i_row_end;
        unique case (t_action'(i_action))
            ACT_LOAD:    w_op.kind = K_LOAD;
            ACT_NONZERO: w_op.kind = i_transpose ? K_SCATTER : K_MAC;
            ACT_EMPTY:   w_op.kind = i_transpose ? K_ADVANCE : K_EMPTY;
            ACT_READ:    w_op.kind = K_READ;
            default:     w_op.kind = K_READ;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2) | i_hold;
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_q[r_rp];
    assign w_acc   = i_push & ~o_full;
    assign w_deq   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wp <= ~r_wp;
            end
            if (w_deq) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, w_deq};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/csm_outq.sv -----
// Result queue between the back end and the result ports.
`default_nettype none
module csm_outq (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_push,
    input  csm_pkg::t_result            i_data,
    input  wire                         i_pop,
    output logic                        o_empty,
    output csm_pkg::t_result            o_data,
    output logic [csm_pkg::OQ_CW-1:0]   o_count
);
    import csm_pkg::*;

    localparam int PW = $clog2(OQ_DEPTH);

    t_result          r_q [OQ_DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [OQ_CW-1:0] r_cnt;
    logic             w_deq;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rp];
    assign o_count = r_cnt;
    assign w_deq   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_deq) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + OQ_CW'(i_push) - OQ_CW'(w_deq);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/csm_back.sv -----
// Back end: vector and result stores, multiply pipeline, row sums and scatter updates.
`default_nettype none
module csm_back #(
    parameter int VEC_DEPTH = 1024
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    input  csm_pkg::t_op                i_op,
    output logic                        o_pop,
    output logic                        o_clr_busy,
    input  wire [csm_pkg::NROW_W-1:0]   i_num_rows,
    input  wire [csm_pkg::OQ_CW-1:0]    i_oq_count,
    output logic                        o_push,
    output csm_pkg::t_result            o_result
);
    import csm_pkg::*;

    localparam int AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam logic [16:0] DEPTH_V = 17'(VEC_DEPTH);
    localparam int EW = SUM_W + 1;

    logic signed [VAL_W-1:0] vmem [VEC_DEPTH];
    logic [EW-1:0]           rmem [VEC_DEPTH];

    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_addr;
    logic [IDX_W-1:0]  r_row;
    logic signed [SUM_W-1:0] r_sum;
    logic              r_sum_ovf;

    // stage B
    logic              r_vb;
    t_kind             r_kb;
    logic [IDX_W-1:0]  r_idx_b, r_row_b;
    logic signed [VAL_W-1:0] r_val_b;
    logic              r_last_b, r_vok_b, r_iok_b;
    logic signed [VAL_W-1:0] r_vdata;
    logic [EW-1:0]     r_rdata;

    // stage C
    logic              r_vc;
    t_kind             r_kc;
    logic [IDX_W-1:0]  r_idx_c, r_row_c;
    logic              r_last_c, r_iok_c;
    logic [EW-1:0]     r_rd_c;
    logic signed [SUM_W-1:0] r_prod;

    // recent result store writes for forwarding
    logic              r_w1v, r_w2v;
    logic [AW-1:0]     r_w1a, r_w2a;
    logic [EW-1:0]     r_w1d, r_w2d;

    logic              w_issue, w_emit_b, w_emit_c;
    logic [OQ_CW-1:0]  w_pending;
    logic              w_idx_ok, w_vok;
    logic [AW-1:0]     w_aidx, w_vaddr, w_ac, w_wa;
    logic [NROW_W-1:0] w_lim, w_nxt;
    logic              w_adv;
    logic signed [VAL_W-1:0] w_vec;
    logic [EW-1:0]     w_ent, w_cwd, w_wd;
    logic [SUM_W:0]    w_s_row, w_s_ent;
    logic              w_cwe, w_we;

    function automatic logic in_range(input logic [IDX_W-1:0] x);
        return ({7'b0, x} < DEPTH_V);
    endfunction

    // stage A: issue
    assign w_emit_b  = r_vb & (((r_kb == K_MAC) & r_last_b) | (r_kb == K_EMPTY) |
                               (r_kb == K_READ));
    assign w_emit_c  = r_vc & (((r_kc == K_MAC) & r_last_c) | (r_kc == K_EMPTY) |
                               (r_kc == K_READ));
    assign w_pending = i_oq_count + OQ_CW'(w_emit_b) + OQ_CW'(w_emit_c);
    assign w_issue   = i_valid & ~r_clr_busy & (w_pending < OQ_CW'(OQ_DEPTH));
    assign o_pop     = w_issue;
    assign o_clr_busy = r_clr_busy;

    assign w_idx_ok = in_range(i_op.idx);
    assign w_aidx   = AW'(i_op.idx);
    assign w_vaddr  = (i_op.kind == K_SCATTER) ? AW'(r_row) : w_aidx;
    assign w_vok    = (i_op.kind == K_SCATTER) ? in_range(r_row) : w_idx_ok;

    assign w_lim = ((i_num_rows == '0) || (i_num_rows > ROW_LIMIT)) ? ROW_LIMIT : i_num_rows;
    assign w_nxt = {1'b0, r_row} + 11'd1;
    assign w_adv = w_issue & ((i_op.kind == K_EMPTY) || (i_op.kind == K_ADVANCE) ||
                   (((i_op.kind == K_MAC) || (i_op.kind == K_SCATTER)) && i_op.last));

    always_ff @(posedge i_clk) begin
        if (w_issue && (i_op.kind == K_LOAD) && w_idx_ok) begin
            vmem[w_aidx] <= i_op.val;
        end
        r_vdata <= vmem[w_vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            rmem[w_wa] <= w_wd;
        end
        r_rdata <= rmem[w_aidx];
    end

    // stage B: multiply
    assign w_vec = r_vok_b ? r_vdata : '0;

    always_ff @(posedge i_clk) begin
        r_kb     <= i_op.kind;
        r_idx_b  <= i_op.idx;
        r_val_b  <= i_op.val;
        r_last_b <= i_op.last;
        r_row_b  <= r_row;
        r_vok_b  <= w_vok;
        r_iok_b  <= w_idx_ok;
        r_kc     <= r_kb;
        r_idx_c  <= r_idx_b;
        r_row_c  <= r_row_b;
        r_last_c <= r_last_b;
        r_iok_c  <= r_iok_b;
        r_rd_c   <= r_rdata;
        r_prod   <= SUM_W'(r_val_b * w_vec);
    end

    // stage C: accumulate, scatter, emit
    assign w_ac  = AW'(r_idx_c);
    assign w_ent = (r_w1v && (r_w1a == w_ac)) ? r_w1d :
                   (r_w2v && (r_w2a == w_ac)) ? r_w2d : r_rd_c;
    assign w_s_row = sat_add(r_sum, r_prod);
    assign w_s_ent = sat_add(w_ent[SUM_W-1:0], r_prod);

    always_comb begin
        w_cwe    = 1'b0;
        w_cwd    = '0;
        o_push   = 1'b0;
        o_result = '0;
        if (r_vc) begin
            case (r_kc)
                K_MAC: begin
                    o_push         = r_last_c;
                    o_result.value = w_s_row[SUM_W-1:0];
                    o_result.row   = r_row_c;
                    o_result.ovf   = r_sum_ovf | w_s_row[SUM_W];
                end
                K_EMPTY: begin
                    o_push       = 1'b1;
                    o_result.row = r_row_c;
                end
                K_SCATTER: begin
                    w_cwe = r_iok_c;
                    w_cwd = {w_ent[SUM_W] | w_s_ent[SUM_W], w_s_ent[SUM_W-1:0]};
                end
                K_READ: begin
                    o_push         = 1'b1;
                    w_cwe          = r_iok_c;
                    o_result.value = r_iok_c ? w_ent[SUM_W-1:0] : '0;
                    o_result.ovf   = r_iok_c & w_ent[SUM_W];
                    o_result.row   = r_idx_c;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_we = r_clr_busy | w_cwe;
    assign w_wa = r_clr_busy ? r_clr_addr : w_ac;
    assign w_wd = r_clr_busy ? '0 : w_cwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_row      <= '0;
            r_sum      <= '0;
            r_sum_ovf  <= 1'b0;
            r_vb       <= 1'b0;
            r_vc       <= 1'b0;
            r_w1v      <= 1'b0;
            r_w2v      <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(VEC_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_adv) begin
                r_row <= (w_nxt >= w_lim) ? '0 : w_nxt[IDX_W-1:0];
            end
            r_vb  <= w_issue;
            r_vc  <= r_vb;
            r_w1v <= w_cwe;
            r_w2v <= r_w1v;
            if (r_vc && (r_kc == K_MAC)) begin
                if (r_last_c) begin
                    r_sum     <= '0;
                    r_sum_ovf <= 1'b0;
                end else begin
                    r_sum     <= w_s_row[SUM_W-1:0];
                    r_sum_ovf <= r_sum_ovf | w_s_row[SUM_W];
                end
            end else if (r_vc && (r_kc == K_EMPTY)) begin
                r_sum     <= '0;
                r_sum_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w1a <= w_ac;
        r_w1d <= w_cwd;
        r_w2a <= r_w1a;
        r_w2d <= r_w1d;
    end

    a_no_issue_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !w_issue)
        else $error("item issued during result store clear");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_oq_count < OQ_CW'(OQ_DEPTH)))
        else $error("result pushed into full queue");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pending <= OQ_CW'(OQ_DEPTH))
        else $error("results in flight exceed queue room");

    a_no_cwrite_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !w_cwe)
        else $error("scatter write during clear");
endmodule
`default_nettype wire

// ----- rtl/csr_sparse_matvec.sv -----
// Top level: CSR sparse matrix-vector multiply with register port and queue channels.
//
// Input channel: push/full; an item transfers when push is high and full is low.
// Result channel: empty/pop; the oldest result sits on o_result_value, o_row_index and
// o_overflow while empty is low, and transfers when pop is high.
// Register port (APB style, pready tied high): transpose at 0x0, num_rows at 0x4.
// Write registers only while the block is idle.
// Throughput: one item per cycle while the result queue has room and no store clear
// runs; the front queue, a three-stage back end (store read, 32x32 multiply, 64-bit
// saturating add with store write-back) and the result queue keep each side moving.
// Results pass from the front queue through stages B and C into the result queue.
// Back-to-back updates of one result store entry are forwarded from the last two writes.
// After reset the result store is cleared one entry a cycle, over all entries, with
// full held high; register writes are taken throughout.
// When the receiver stalls, the result queue (four deep) fills, the back end stops
// issuing, and full rises once the two-entry front queue is occupied.
`default_nettype none
module csr_sparse_matvec #(
    parameter int VEC_DEPTH = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [2:0]                    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire                          push,
    output logic                         full,
    input  wire [1:0]                    i_action,
    input  wire [csm_pkg::IDX_W-1:0]     i_index,
    input  wire signed [csm_pkg::VAL_W-1:0] i_value,
    input  wire                          i_row_end,
    output logic                         empty,
    input  wire                          pop,
    output logic signed [csm_pkg::SUM_W-1:0] o_result_value,
    output logic [csm_pkg::IDX_W-1:0]    o_row_index,
    output logic                         o_overflow
);
    import csm_pkg::*;

    logic              r_transpose;
    logic [NROW_W-1:0] r_num_rows;
    logic              w_wr;
    logic              w_qvalid, w_qpop, w_clr_busy, w_bpush;
    t_op               w_op;
    t_result           w_bres, w_ores;
    logic [OQ_CW-1:0]  w_oq_count;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose <= 1'b0;
            r_num_rows  <= ROW_LIMIT;
        end else if (w_wr) begin
            if (paddr == REG_TRANSPOSE) begin
                r_transpose <= pwdata[0];
            end else if (paddr == REG_NUM_ROWS) begin
                r_num_rows <= pwdata[NROW_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr)
            REG_TRANSPOSE: prdata = {31'b0, r_transpose};
            REG_NUM_ROWS:  prdata = {21'b0, r_num_rows};
            default:       prdata = '0;
        endcase
    end

    csm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_action    (i_action),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_row_end   (i_row_end),
        .i_transpose (r_transpose),
        .i_hold      (w_clr_busy),
        .o_full      (full),
        .i_pop       (w_qpop),
        .o_valid     (w_qvalid),
        .o_op        (w_op)
    );

    csm_back #(
        .VEC_DEPTH (VEC_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_qvalid),
        .i_op       (w_op),
        .o_pop      (w_qpop),
        .o_clr_busy (w_clr_busy),
        .i_num_rows (r_num_rows),
        .i_oq_count (w_oq_count),
        .o_push     (w_bpush),
        .o_result   (w_bres)
    );

    csm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_bpush),
        .i_data  (w_bres),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_ores),
        .o_count (w_oq_count)
    );

    assign o_result_value = w_ores.value;
    assign o_row_index    = w_ores.row;
    assign o_overflow     = w_ores.ovf;
endmodule
`default_nettype wire
